FILE: hdl/ggn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggn_pkg
// Shared types and constants of the grid gradient-norm stencil.
// ----------------------------------------------------------------------------
package ggn_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int CFG_WIDTH       = 11;
    localparam int MIN_GRID        = 3;
    localparam logic [CFG_WIDTH-1:0] CFG_SIZE_RESET = 11'd1024;

    typedef enum logic [0:0] {
        CFG_NUM_COLUMNS = 1'b0,
        CFG_NUM_ROWS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic signed [31:0] column_coord;
        logic signed [31:0] row_coord;
        logic [9:0]         range_first;
        logic [9:0]         range_last;
    } in_req_t;

    typedef struct packed {
        logic [31:0] grad_norm;
        logic [9:0]  node_column;
        logic [9:0]  node_row;
        logic        run_last;
    } out_req_t;

    typedef enum logic [1:0] {
        GX_FWD,
        GX_BWD,
        GX_MID
    } gx_mode_t;

    // y stencil (f-, f0, f+ over y-, y0, y+) and x stencil (v-, v0, v+ over x-, x0, x+)
    typedef struct packed {
        logic signed [31:0] fm, f0, fp, ym, y0, yp;
        logic signed [31:0] vm, v0, vp, xm, x0, xp;
        gx_mode_t           gx_mode;
    } calc_opnd_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_READ,
        T_CALC,
        T_WAIT,
        T_COMMIT
    } top_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_SETUP,
        C_MLOAD,
        C_MUL,
        C_DLOAD,
        C_DSAT,
        C_DIV,
        C_SQLOAD,
        C_SQRT
    } calc_state_t;

    typedef enum logic [2:0] {
        MS_BB,
        MS_BBDP,
        MS_AA,
        MS_AADM,
        MS_AB,
        MS_ABS,
        MS_GX2,
        MS_GY2
    } mul_step_t;

endpackage

FILE: hdl/ggn_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggn_calc
// Sequential gradient-norm unit: shared 128x8 multiplier, radix-2 divider
// and bit-pair square root. Operands must hold from start until done.
// ----------------------------------------------------------------------------
module ggn_calc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ggn_pkg::calc_opnd_t opnd,
    output logic               done,
    output logic [31:0]        grad
);
    import ggn_pkg::*;

    localparam int OW = 34;
    localparam int PW = 128;
    localparam int DW = 136;
    localparam logic [32:0] G_SAT = {1'b1, 32'd0};

    calc_state_t state_reg, state_next;
    mul_step_t   ms_reg, ms_next;
    logic        phase_reg, phase_next;
    logic [2:0]  mk_reg, mk_next;
    logic [4:0]  dk_reg, dk_next;
    logic [4:0]  sk_reg, sk_next;
    logic        done_reg, done_next;

    logic signed [OW-1:0] a_reg, a_next, b_reg, b_next, s_reg, s_next;
    logic signed [OW-1:0] dp_reg, dp_next, dm_reg, dm_next;
    logic signed [PW-1:0] t_reg, t_next, n1_reg, n1_next, num_reg, num_next;
    logic signed [PW-1:0] macc_reg, macc_next, mx_reg, mx_next;
    logic [39:0]          mym_reg, mym_next;
    logic [DW-1:0]        nn_reg, nn_next, dd_reg, dd_next;
    logic [31:0]          q_reg, q_next;
    logic [32:0]          gy_reg, gy_next, gx_reg, gx_next;
    logic [63:0]          sqv_reg, sqv_next, sqr_reg, sqr_next, sqb_reg, sqb_next;
    logic [31:0]          grad_reg, grad_next;

    always_comb
    begin
        logic signed [31:0]   tm, t0, tp, cm, c0, cp, v1, x1;
        logic signed [OW-1:0] a_c, b_c, s_c, df, dx, mul_y;
        logic [OW-1:0]        df_mag, dx_mag, my_mag;
        logic signed [PW-1:0] mul_x, pp, prod;
        logic [PW-1:0]        num_abs, den_abs;
        logic [64:0]          sq_sum;
        logic [63:0]          sq_try;
        logic [31:0]          q_new;
        logic                 ge, fin;
        logic [32:0]          fin_val;

        state_next = state_reg;
        ms_next    = ms_reg;
        phase_next = phase_reg;
        mk_next    = mk_reg;
        dk_next    = dk_reg;
        sk_next    = sk_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        s_next     = s_reg;
        dp_next    = dp_reg;
        dm_next    = dm_reg;
        t_next     = t_reg;
        n1_next    = n1_reg;
        num_next   = num_reg;
        macc_next  = macc_reg;
        mx_next    = mx_reg;
        mym_next   = mym_reg;
        nn_next    = nn_reg;
        dd_next    = dd_reg;
        q_next     = q_reg;
        gy_next    = gy_reg;
        gx_next    = gx_reg;
        sqv_next   = sqv_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        grad_next  = grad_reg;
        fin        = 1'b0;
        fin_val    = '0;

        if (!phase_reg)
        begin
            tm = opnd.fm; t0 = opnd.f0; tp = opnd.fp;
            cm = opnd.ym; c0 = opnd.y0; cp = opnd.yp;
        end
        else
        begin
            tm = opnd.vm; t0 = opnd.v0; tp = opnd.vp;
            cm = opnd.xm; c0 = opnd.x0; cp = opnd.xp;
        end
        a_c = OW'(cp) - OW'(c0);
        b_c = OW'(c0) - OW'(cm);
        s_c = OW'(cp) - OW'(cm);

        v1 = (opnd.gx_mode == GX_FWD) ? opnd.vp : opnd.vm;
        x1 = (opnd.gx_mode == GX_FWD) ? opnd.xp : opnd.xm;
        df = OW'(v1) - OW'(opnd.v0);
        dx = OW'(x1) - OW'(opnd.x0);
        df_mag = df[OW-1] ? OW'(-df) : OW'(df);
        dx_mag = dx[OW-1] ? OW'(-dx) : OW'(dx);

        case (ms_reg)
            MS_BB:   begin mul_x = PW'(b_reg); mul_y = b_reg;  end
            MS_BBDP: begin mul_x = t_reg;      mul_y = dp_reg; end
            MS_AA:   begin mul_x = PW'(a_reg); mul_y = a_reg;  end
            MS_AADM: begin mul_x = t_reg;      mul_y = dm_reg; end
            MS_AB:   begin mul_x = PW'(a_reg); mul_y = b_reg;  end
            MS_ABS:  begin mul_x = t_reg;      mul_y = s_reg;  end
            MS_GX2:  begin mul_x = PW'(gx_reg[31:0]); mul_y = OW'(gx_reg[31:0]); end
            MS_GY2:  begin mul_x = PW'(gy_reg[31:0]); mul_y = OW'(gy_reg[31:0]); end
            default: begin mul_x = '0; mul_y = '0; end
        endcase
        my_mag = mul_y[OW-1] ? OW'(-mul_y) : OW'(mul_y);

        pp   = mx_reg * $signed({1'b0, mym_reg[7:0]});
        prod = macc_reg + pp;

        num_abs = num_reg[PW-1] ? PW'(-num_reg) : PW'(num_reg);
        den_abs = t_reg[PW-1] ? PW'(-t_reg) : PW'(t_reg);

        ge    = nn_reg >= dd_reg;
        q_new = {q_reg[30:0], ge};

        sq_sum = 65'(n1_reg[63:0]) + 65'(t_reg[63:0]);
        sq_try = sqr_reg + sqb_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    phase_next = 1'b0;
                    state_next = C_SETUP;
                end
            end
            C_SETUP:
            begin
                if (phase_reg && opnd.gx_mode != GX_MID)
                begin
                    nn_next = DW'(df_mag) << 16;
                    dd_next = DW'(dx_mag);
                    if (dx == '0)
                    begin
                        fin     = 1'b1;
                        fin_val = G_SAT;
                    end
                    else
                    begin
                        state_next = C_DSAT;
                    end
                end
                else
                begin
                    a_next  = a_c;
                    b_next  = b_c;
                    s_next  = s_c;
                    dp_next = OW'(tp) - OW'(t0);
                    dm_next = OW'(t0) - OW'(tm);
                    ms_next = MS_BB;
                    if (a_c == '0 || b_c == '0 || s_c == '0)
                    begin
                        fin     = 1'b1;
                        fin_val = G_SAT;
                    end
                    else
                    begin
                        state_next = C_MLOAD;
                    end
                end
            end
            C_MLOAD:
            begin
                mx_next   = mul_y[OW-1] ? -mul_x : mul_x;
                mym_next  = 40'(my_mag);
                macc_next = '0;
                mk_next   = '0;
                if (ms_reg == MS_AB)
                begin
                    num_next = n1_reg + t_reg;
                end
                state_next = C_MUL;
            end
            C_MUL:
            begin
                macc_next = prod;
                mx_next   = mx_reg << 8;
                mym_next  = mym_reg >> 8;
                mk_next   = mk_reg + 3'd1;
                if (mk_reg == 3'd4)
                begin
                    state_next = C_MLOAD;
                    case (ms_reg)
                        MS_BB:   begin t_next  = prod; ms_next = MS_BBDP; end
                        MS_BBDP: begin n1_next = prod; ms_next = MS_AA;   end
                        MS_AA:   begin t_next  = prod; ms_next = MS_AADM; end
                        MS_AADM: begin t_next  = prod; ms_next = MS_AB;   end
                        MS_AB:   begin t_next  = prod; ms_next = MS_ABS;  end
                        MS_ABS:  begin t_next  = prod; state_next = C_DLOAD; end
                        MS_GX2:  begin n1_next = prod; ms_next = MS_GY2;  end
                        MS_GY2:  begin t_next  = prod; state_next = C_SQLOAD; end
                        default: state_next = C_IDLE;
                    endcase
                end
            end
            C_DLOAD:
            begin
                nn_next    = DW'(num_abs) << 16;
                dd_next    = DW'(den_abs);
                state_next = C_DSAT;
            end
            C_DSAT:
            begin
                if (nn_reg >= (dd_reg << 32))
                begin
                    fin     = 1'b1;
                    fin_val = G_SAT;
                end
                else
                begin
                    dd_next    = dd_reg << 31;
                    dk_next    = 5'd31;
                    q_next     = '0;
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                if (ge)
                begin
                    nn_next = nn_reg - dd_reg;
                end
                q_next  = q_new;
                dd_next = dd_reg >> 1;
                dk_next = dk_reg - 5'd1;
                if (dk_reg == '0)
                begin
                    fin     = 1'b1;
                    fin_val = {1'b0, q_new};
                end
            end
            C_SQLOAD:
            begin
                if (sq_sum[64])
                begin
                    grad_next  = '1;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    sqv_next   = sq_sum[63:0];
                    sqr_next   = '0;
                    sqb_next   = 64'h4000_0000_0000_0000;
                    sk_next    = 5'd31;
                    state_next = C_SQRT;
                end
            end
            C_SQRT:
            begin
                if (sqv_reg >= sq_try)
                begin
                    sqv_next = sqv_reg - sq_try;
                    sqr_next = (sqr_reg >> 1) + sqb_reg;
                end
                else
                begin
                    sqr_next = sqr_reg >> 1;
                end
                sqb_next = sqb_reg >> 2;
                sk_next  = sk_reg - 5'd1;
                if (sk_reg == '0)
                begin
                    grad_next  = sqr_next[31:0];
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase

        // one gradient term finished: y first, then x, then the norm
        if (fin)
        begin
            if (!phase_reg)
            begin
                gy_next    = fin_val;
                phase_next = 1'b1;
                state_next = C_SETUP;
            end
            else
            begin
                gx_next = fin_val;
                if (fin_val[32] || gy_reg[32])
                begin
                    grad_next  = '1;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    ms_next    = MS_GX2;
                    state_next = C_MLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            ms_reg    <= MS_BB;
            phase_reg <= 1'b0;
            mk_reg    <= '0;
            dk_reg    <= '0;
            sk_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ms_reg    <= ms_next;
            phase_reg <= phase_next;
            mk_reg    <= mk_next;
            dk_reg    <= dk_next;
            sk_reg    <= sk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        s_reg    <= s_next;
        dp_reg   <= dp_next;
        dm_reg   <= dm_next;
        t_reg    <= t_next;
        n1_reg   <= n1_next;
        num_reg  <= num_next;
        macc_reg <= macc_next;
        mx_reg   <= mx_next;
        mym_reg  <= mym_next;
        nn_reg   <= nn_next;
        dd_reg   <= dd_next;
        q_reg    <= q_next;
        gy_reg   <= gy_next;
        gx_reg   <= gx_next;
        sqv_reg  <= sqv_next;
        sqr_reg  <= sqr_next;
        sqb_reg  <= sqb_next;
        grad_reg <= grad_next;
    end

    assign done = done_reg;
    assign grad = grad_reg;

endmodule

FILE: hdl/grid_gradient_norm_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_gradient_norm_stencil
// Gradient norm on a non-uniform grid, streamed in raster order.
//
// Nodes enter on in_valid/in_ready, one request per node, columns fastest.
// Results leave on out_valid/out_ready: a node of row r is reported while
// row r+1 streams in; last-row nodes also report their own zero. run_last
// marks the final result of a request. num_columns/num_rows are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while
// the block is idle, which the block does not enforce. One node at a time:
// the node is accepted, the two row banks and column coordinates are read,
// an interior node then runs in the shared arithmetic unit (6 multiplies
// and a divide per three-point term, a divide per one-sided term, 2 squares
// and a root) and the node is committed; off-range nodes skip the unit.
// Reset clears positions, row coordinates, ranges and the result queue;
// the value and coordinate memories are not cleared. A two-deep result
// queue decouples the receiver; a stalled receiver stops commits only
// when the queue cannot take the node's results.
// ----------------------------------------------------------------------------
module grid_gradient_norm_stencil #(
    parameter int MAX_COLUMNS = ggn_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = ggn_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ggn_pkg::in_req_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ggn_pkg::out_req_t                out_data,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [ggn_pkg::CFG_WIDTH-1:0]    cfg_data
);
    import ggn_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CNW = (CW + 1 > CFG_WIDTH) ? CW + 1 : CFG_WIDTH;
    localparam int RNW = (RW + 1 > CFG_WIDTH) ? RW + 1 : CFG_WIDTH;

    top_state_t state_reg, state_next;
    logic [2:0]           rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    logic                 sel_reg, sel_next;
    logic [9:0]           hfirst_reg, hfirst_next, hlast_reg, hlast_next;
    logic signed [31:0]   py0_reg, py0_next, py1_reg, py1_next;
    logic [CFG_WIDTH-1:0] ncol_cfg_reg, ncol_cfg_next, nrow_cfg_reg, nrow_cfg_next;
    logic [1:0]           cnt_reg, cnt_next;

    in_req_t              req_reg, req_next;
    logic signed [31:0]   fm_reg, fm_next, v0_reg, v0_next, vm_reg, vm_next;
    logic signed [31:0]   vp_reg, vp_next, xm_reg, xm_next, x0_reg, x0_next;
    logic signed [31:0]   xp_reg, xp_next;
    logic [31:0]          g_reg, g_next;
    out_req_t             q0_reg, q0_next, q1_reg, q1_next;

    logic [31:0]          val_mem [2][MAX_COLUMNS];
    logic [31:0]          crd_mem [MAX_COLUMNS];
    logic [31:0]          val_q, crd_q;
    logic                 val_rbank;
    logic [CW-1:0]        val_raddr, crd_raddr;
    logic                 mem_we;

    logic [CNW-1:0]       nc, lastc, colw, hl_eff;
    logic [RNW-1:0]       nr, lastr, roww;
    logic [CW-1:0]        col_m1, col_p1;
    logic [RW-1:0]        r_idx;
    logic                 row_ge1, in_rng, emit_last, col_end, room;
    logic [1:0]           n_out;
    gx_mode_t             gx_mode;
    calc_opnd_t           opnd;
    logic                 calc_start, calc_done;
    logic [31:0]          calc_grad;
    out_req_t             p_node, p_own, p0;

    always_comb
    begin
        logic [CNW-1:0] ncw;
        logic [RNW-1:0] nrw;

        ncw = CNW'(ncol_cfg_reg);
        nrw = RNW'(nrow_cfg_reg);
        if (ncw < CNW'(MIN_GRID))
            nc = CNW'(MIN_GRID);
        else if (ncw > CNW'(MAX_COLUMNS))
            nc = CNW'(MAX_COLUMNS);
        else
            nc = ncw;
        if (nrw < RNW'(MIN_GRID))
            nr = RNW'(MIN_GRID);
        else if (nrw > RNW'(MAX_ROWS))
            nr = RNW'(MAX_ROWS);
        else
            nr = nrw;
    end

    assign lastc     = nc - 1'b1;
    assign lastr     = nr - 1'b1;
    assign colw      = CNW'(col_reg);
    assign roww      = RNW'(row_reg);
    assign col_m1    = col_reg - 1'b1;
    assign col_p1    = col_reg + 1'b1;
    assign r_idx     = row_reg - 1'b1;
    assign hl_eff    = (CNW'(hlast_reg) < lastc) ? CNW'(hlast_reg) : lastc;
    assign row_ge1   = row_reg != '0;
    assign in_rng    = (roww >= RNW'(2)) && (colw >= CNW'(hfirst_reg)) && (colw <= hl_eff);
    assign emit_last = roww >= lastr;
    assign col_end   = colw >= lastc;
    assign n_out     = 2'(row_ge1) + 2'(emit_last);
    assign room      = (3'(cnt_reg) + 3'(n_out)) <= 3'd2;

    always_comb
    begin
        if (colw == CNW'(hfirst_reg) && (colw + 1'b1) < nc)
            gx_mode = GX_FWD;
        else if (colw == CNW'(hfirst_reg) || colw == hl_eff)
            gx_mode = GX_BWD;
        else
            gx_mode = GX_MID;
    end

    assign opnd = '{fm: fm_reg, f0: v0_reg, fp: req_reg.sample_value,
                    ym: py0_reg, y0: py1_reg, yp: req_reg.row_coord,
                    vm: vm_reg, v0: v0_reg, vp: vp_reg,
                    xm: xm_reg, x0: x0_reg, xp: xp_reg, gx_mode: gx_mode};

    ggn_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .opnd  (opnd),
        .done  (calc_done),
        .grad  (calc_grad)
    );

    // read order: f- (older bank), f0, v-, v+ ; x-, x0, x+
    always_comb
    begin
        case (rd_idx_reg)
            3'd0:    begin val_rbank = ~sel_reg; val_raddr = col_reg; crd_raddr = col_m1;  end
            3'd1:    begin val_rbank = sel_reg;  val_raddr = col_reg; crd_raddr = col_reg; end
            3'd2:    begin val_rbank = sel_reg;  val_raddr = col_m1;  crd_raddr = col_p1;  end
            default: begin val_rbank = sel_reg;  val_raddr = col_p1;  crd_raddr = col_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            val_mem[~sel_reg][col_reg] <= req_reg.sample_value;
        end
        val_q <= val_mem[val_rbank][val_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && !row_ge1)
        begin
            crd_mem[col_reg] <= req_reg.column_coord;
        end
        crd_q <= crd_mem[crd_raddr];
    end

    assign p_node = '{grad_norm: g_reg, node_column: 10'(col_reg),
                      node_row: 10'(r_idx), run_last: !emit_last};
    assign p_own  = '{grad_norm: 32'd0, node_column: 10'(col_reg),
                      node_row: 10'(row_reg), run_last: 1'b1};
    assign p0     = row_ge1 ? p_node : p_own;

    always_comb
    begin
        logic       pop;
        logic [1:0] c_after;

        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        sel_next      = sel_reg;
        hfirst_next   = hfirst_reg;
        hlast_next    = hlast_reg;
        py0_next      = py0_reg;
        py1_next      = py1_reg;
        ncol_cfg_next = ncol_cfg_reg;
        nrow_cfg_next = nrow_cfg_reg;
        req_next      = req_reg;
        fm_next       = fm_reg;
        v0_next       = v0_reg;
        vm_next       = vm_reg;
        vp_next       = vp_reg;
        xm_next       = xm_reg;
        x0_next       = x0_reg;
        xp_next       = xp_reg;
        g_next        = g_reg;
        in_ready      = 1'b0;
        calc_start    = 1'b0;
        mem_we        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_COLUMNS: ncol_cfg_next = cfg_data;
                CFG_NUM_ROWS:    nrow_cfg_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            T_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next    = in_data;
                    rd_idx_next = '0;
                    state_next  = T_READ;
                end
            end
            T_READ:
            begin
                rd_idx_next = rd_idx_reg + 3'd1;
                case (rd_idx_reg)
                    3'd1:    begin fm_next = $signed(val_q); xm_next = $signed(crd_q); end
                    3'd2:    begin v0_next = $signed(val_q); x0_next = $signed(crd_q); end
                    3'd3:    begin vm_next = $signed(val_q); xp_next = $signed(crd_q); end
                    3'd4:    vp_next = $signed(val_q);
                    default: ;
                endcase
                if (rd_idx_reg == 3'd4)
                begin
                    g_next     = '0;
                    state_next = in_rng ? T_CALC : T_COMMIT;
                end
            end
            T_CALC:
            begin
                calc_start = 1'b1;
                state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (calc_done)
                begin
                    g_next     = calc_grad;
                    state_next = T_COMMIT;
                end
            end
            T_COMMIT:
            begin
                if (room)
                begin
                    mem_we     = 1'b1;
                    state_next = T_IDLE;
                    if (col_end)
                    begin
                        col_next    = '0;
                        hfirst_next = req_reg.range_first;
                        hlast_next  = req_reg.range_last;
                        py0_next    = py1_reg;
                        py1_next    = req_reg.row_coord;
                        sel_next    = ~sel_reg;
                        row_next    = emit_last ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default: state_next = T_IDLE;
        endcase

        pop     = (cnt_reg != 2'd0) && out_ready;
        c_after = cnt_reg - 2'(pop);
        q0_next = pop ? q1_reg : q0_reg;
        q1_next = q1_reg;
        cnt_next = c_after;
        if (mem_we)
        begin
            if (c_after == 2'd0)
            begin
                q0_next = p0;
                q1_next = p_own;
            end
            else
            begin
                q1_next = p0;
            end
            cnt_next = c_after + n_out;
        end
    end

    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = q0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            rd_idx_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            sel_reg      <= 1'b0;
            hfirst_reg   <= '0;
            hlast_reg    <= '0;
            py0_reg      <= '0;
            py1_reg      <= '0;
            ncol_cfg_reg <= CFG_SIZE_RESET;
            nrow_cfg_reg <= CFG_SIZE_RESET;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            sel_reg      <= sel_next;
            hfirst_reg   <= hfirst_next;
            hlast_reg    <= hlast_next;
            py0_reg      <= py0_next;
            py1_reg      <= py1_next;
            ncol_cfg_reg <= ncol_cfg_next;
            nrow_cfg_reg <= nrow_cfg_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        fm_reg  <= fm_next;
        v0_reg  <= v0_next;
        vm_reg  <= vm_next;
        vp_reg  <= vp_next;
        xm_reg  <= xm_next;
        x0_reg  <= x0_next;
        xp_reg  <= xp_next;
        g_reg   <= g_next;
        q0_reg  <= q0_next;
        q1_reg  <= q1_next;
    end

endmodule
